// ===== design/vulp_pkg.sv =====
// Shared types and constants for the video-memory update list parser.
// No dependencies; imported by every module of the block.
package vulp_pkg;

  localparam int unsigned BufLenW   = 10;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 9;

  localparam logic [BufLenW-1:0] BufLenReset = 10'd510;
  localparam logic [BufLenW-1:0] PosMax      = 10'd1023;
  localparam logic [CountW-1:0]  FullLength  = 9'd256;
  localparam logic [AddrW-1:0]   StepOne     = 16'd1;
  localparam logic [AddrW-1:0]   StepWide    = 16'd32;

  // Input operation codes
  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_START = 1'b1
  } op_e;

  // One result transaction
  typedef struct packed {
    logic [AddrW-1:0]  write_address;
    logic [ByteW-1:0]  write_data;
    logic              step_by_32;
    logic [CountW-1:0] write_count;
    logic              finished;
  } result_t;

  // One input transaction as held in the input register
  typedef struct packed {
    logic             op;
    logic [ByteW-1:0] list_byte;
  } item_t;

endpackage

// ===== design/vram_update_list_parser.sv =====
// A byte accepted into the input register is decoded by the parser; its result (if any) goes to the output register.
// Throughput: one list byte per cycle while the result is not stalled; the parser state updates per byte.
// A stalled result holds the output register; one more byte waits in the input register.
// Reset (rst_ni low, async): no transactions held, parser at entry start,
// buffer_length back to 510. Top level; depends on vulp_pkg and the vulp_* stages.
module vram_update_list_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vulp_pkg::BufLenW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [7:0]                   list_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [15:0]                  write_address_o,
  output logic [7:0]                   write_data_o,
  output logic                         step_by_32_o,
  output logic [8:0]                   write_count_o,
  output logic                         finished_o
);
  import vulp_pkg::*;

  item_t   in_item, held_item;
  logic    held_valid;
  logic    advance;
  logic    res_valid;
  result_t res, out_res;

  assign in_item.op        = op_i;
  assign in_item.list_byte = list_byte_i;

  vulp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .advance_i    (advance),
    .item_valid_o (held_valid),
    .item_o       (held_item)
  );

  vulp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (held_valid && advance),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  vulp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign write_address_o = out_res.write_address;
  assign write_data_o    = out_res.write_data;
  assign step_by_32_o    = out_res.step_by_32;
  assign write_count_o   = out_res.write_count;
  assign finished_o      = out_res.finished;

endmodule

// ===== design/vulp_in_stage.sv =====
// Input register stage: captures one list byte transaction per cycle while it is free.
// Depends on vulp_pkg.
module vulp_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vulp_pkg::item_t item_i,
  input  logic            advance_i,
  output logic            item_valid_o,
  output vulp_pkg::item_t item_o
);
  import vulp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // Free when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== design/vulp_parser.sv =====
// Parser state and per-byte decode: phase, position, address and count.
// Holds the buffer_length register. Depends on vulp_pkg.
module vulp_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vulp_pkg::BufLenW-1:0]    cfg_wdata_i,
  input  logic                            step_i,
  input  vulp_pkg::item_t                 item_i,
  output logic                            res_valid_o,
  output vulp_pkg::result_t               res_o
);
  import vulp_pkg::*;

  typedef enum logic [2:0] {
    PH_ADDR_HI = 3'd0,
    PH_ADDR_LO = 3'd1,
    PH_CONTROL = 3'd2,
    PH_DATA    = 3'd3,
    PH_FILL    = 3'd4
  } phase_e;

  logic [BufLenW-1:0] buf_len_q;
  logic [BufLenW-1:0] pos_q, pos_d;
  phase_e             phase_q, phase_d;
  logic [AddrW-1:0]   addr_q, addr_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic               vert_q, vert_d;
  logic               fill_q, fill_d;
  logic               done_q, done_d;

  logic               at_limit;
  logic [CountW-1:0]  ctrl_len;
  logic [AddrW-1:0]   addr_step;

  // Entry start check: pos + 2 >= buffer_length
  assign at_limit  = ({1'b0, pos_q} + 11'd2) >= {1'b0, buf_len_q};
  assign ctrl_len  = (item_i.list_byte[5:0] == 6'd0) ? FullLength
                                                     : {3'b000, item_i.list_byte[5:0]};
  assign addr_step = vert_q ? StepWide : StepOne;

  // Next state and result
  always_comb begin
    pos_d       = pos_q;
    phase_d     = phase_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    vert_d      = vert_q;
    fill_d      = fill_q;
    done_d      = done_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      if (item_i.op == OP_START) begin
        pos_d   = '0;
        phase_d = PH_ADDR_HI;
        addr_d  = '0;
        cnt_d   = '0;
        vert_d  = 1'b0;
        fill_d  = 1'b0;
        done_d  = 1'b0;
      end else if (!done_q) begin
        if (pos_q != PosMax) begin
          pos_d = pos_q + 10'd1;
        end
        case (phase_q)
          PH_ADDR_LO: begin
            addr_d  = {addr_q[15:8], item_i.list_byte};
            phase_d = PH_CONTROL;
          end
          PH_CONTROL: begin
            cnt_d   = ctrl_len;
            vert_d  = item_i.list_byte[7];
            fill_d  = item_i.list_byte[6];
            phase_d = item_i.list_byte[6] ? PH_FILL : PH_DATA;
          end
          PH_DATA: begin
            res_valid_o         = 1'b1;
            res_o.write_address = addr_q;
            res_o.write_data    = item_i.list_byte;
            res_o.step_by_32    = vert_q;
            res_o.write_count   = 9'd1;
            addr_d              = addr_q + addr_step;
            cnt_d               = cnt_q - 9'd1;
            if (cnt_q == 9'd1) begin
              phase_d = PH_ADDR_HI;
            end
          end
          PH_FILL: begin
            res_valid_o         = 1'b1;
            res_o.write_address = addr_q;
            res_o.write_data    = item_i.list_byte;
            res_o.step_by_32    = vert_q;
            res_o.write_count   = cnt_q;
            phase_d             = PH_ADDR_HI;
          end
          default: begin
            // Entry start, also unused phase codes
            if (at_limit || item_i.list_byte == 8'h00) begin
              res_valid_o    = 1'b1;
              res_o.finished = 1'b1;
              done_d         = 1'b1;
              phase_d        = PH_ADDR_HI;
            end else begin
              addr_d  = {item_i.list_byte, 8'h00};
              phase_d = PH_ADDR_LO;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= BufLenReset;
      pos_q     <= '0;
      phase_q   <= PH_ADDR_HI;
      addr_q    <= '0;
      cnt_q     <= '0;
      vert_q    <= 1'b0;
      fill_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        buf_len_q <= cfg_wdata_i;
      end
      pos_q   <= pos_d;
      phase_q <= phase_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      vert_q  <= vert_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
    end
  end

endmodule

// ===== design/vulp_out_stage.sv =====
// Result register: holds one result transaction until it is taken.
// Depends on vulp_pkg.
module vulp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  vulp_pkg::result_t res_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vulp_pkg::result_t res_o
);
  import vulp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Register can load when empty or being drained
  assign advance_o = !valid_q || out_ready_i;
  assign valid_d   = advance_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/vulp_checker.sv =====
// Port-level checker for the update list parser, bound to the top level.
// Depends on vulp_pkg and vram_update_list_parser.
module vulp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] write_address_o,
  input logic [7:0]  write_data_o,
  input logic        step_by_32_o,
  input logic [8:0]  write_count_o,
  input logic        finished_o
);
  import vulp_pkg::*;

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(write_address_o)
      && $stable(write_data_o) && $stable(write_count_o) && $stable(finished_o))
    else $error("result changed while stalled");

  // Finished transaction carries no write
  a_fin_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> write_count_o == 9'd0 && write_address_o == 16'd0
      && write_data_o == 8'd0 && !step_by_32_o)
    else $error("finished result has write fields");

  // Write transaction has a count of 1..256
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !finished_o |-> write_count_o != 9'd0 && write_count_o <= FullLength)
    else $error("write count out of range");

  // Input side only backs up behind a stalled result
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind vram_update_list_parser vulp_checker u_vulp_checker (.*);
